[src/apa_pkg.sv]
// ----------------------------------------------------------------------------
// Addressed packet pulse alert package
// Constants and codes for the alert unit.
// ----------------------------------------------------------------------------
package apa_pkg;

    // Address every receiver answers to
    localparam logic [7:0]  BROADCAST_ADDR    = 8'hFF;
    // Milliseconds in one on/off time unit
    localparam logic [14:0] UNIT_MS           = 15'd100;

    // Configuration register indexes
    localparam logic        CFG_LOCAL_ADDRESS = 1'b0;
    localparam logic        CFG_STARTUP_HOLD  = 1'b1;

    // Configuration reset values
    localparam logic [7:0]  LOCAL_ADDR_RESET  = 8'hBB;
    localparam logic [15:0] STARTUP_HOLD_RESET = 16'd2000;

    // Header byte positions within a packet
    localparam logic [2:0]  POS_RECIPIENT     = 3'd1;
    localparam logic [2:0]  POS_PULSE_COUNT   = 3'd3;
    localparam logic [2:0]  POS_ON_TIME       = 3'd4;
    localparam logic [2:0]  POS_OFF_TIME      = 3'd5;
    localparam logic [2:0]  POS_LENGTH        = 3'd6;
    localparam logic [2:0]  POS_PAYLOAD       = 3'd7;

    // Input beat kinds
    localparam logic        CMD_TICK          = 1'b0;
    localparam logic        CMD_BYTE          = 1'b1;

    // Saturation limits
    localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;
    localparam logic [14:0] PHASE_MAX         = 15'h7FFF;
    localparam logic [8:0]  PAYLOAD_MAX       = 9'h1FF;

    // Packet status codes reported on the last byte
    typedef enum logic [2:0] {
        STATUS_NONE       = 3'd0,
        STATUS_ACCEPTED   = 3'd1,
        STATUS_BAD_LENGTH = 3'd2,
        STATUS_NOT_ADDR   = 3'd3,
        STATUS_STARTUP    = 3'd4
    } status_t;

endpackage

[src/apa_in_if.sv]
// ----------------------------------------------------------------------------
// Alert input channel
// Valid/ready channel carrying ticks and received packet bytes.
// ----------------------------------------------------------------------------
interface apa_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output command, output data_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input command, input data_byte,
                    input last_byte, output ready);
endinterface

[src/apa_out_if.sv]
// ----------------------------------------------------------------------------
// Alert result channel
// Valid/ready channel carrying one result beat per input beat.
// ----------------------------------------------------------------------------
interface apa_out_if;
    logic       valid;
    logic       ready;
    logic       motor_drive;
    logic [2:0] packet_status;
    logic       pattern_active;

    modport source (output valid, output motor_drive, output packet_status,
                    output pattern_active, input ready);
    modport sink   (input valid, input motor_drive, input packet_status,
                    input pattern_active, output ready);
endinterface

[src/addressed_packet_pulse_alert_unit.sv]
// ----------------------------------------------------------------------------
// Addressed packet pulse alert unit
// Parses addressed packets and drives a timed pulse pattern on acceptance.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one beat per 1 ms tick (command 0) or per packet byte
//          (command 1, last_byte marks the end of a packet).
//   out_ch returns exactly one beat per input beat: motor drive level,
//          packet status (nonzero only on a last byte) and pattern activity.
//   cfg_we/cfg_index/cfg_data write local_address (index 0) and
//          startup_hold_ms (index 1); write only while the unit is idle.
// Result: a result beat is registered and becomes valid in the cycle after its input beat is taken.
// Throughput: one beat per cycle while out_ch takes results; all per-beat work is
//   combinational between the state registers and the result register.
// Stall: the result register is the only buffer; in_ch.ready drops while a
//   result waits and out_ch.ready is low, and no beat is lost.
// Reset: the pattern stops, header fields return to three pulses, 500 ms on,
//   200 ms off, and packets are ignored until the startup hold has counted
//   out in ticks.
// ----------------------------------------------------------------------------
module addressed_packet_pulse_alert_unit (
    input  logic        clk,
    input  logic        rst_n,
    apa_in_if.sink      in_ch,
    apa_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import apa_pkg::*;

    // Configuration registers
    logic [7:0]  local_address_reg;
    logic [15:0] startup_hold_reg;

    // Block state
    logic [15:0] startup_elapsed_reg, startup_elapsed_next;
    logic        startup_done_reg, startup_done_next;
    logic [2:0]  byte_position_reg, byte_position_next;
    logic [7:0]  recipient_seen_reg, recipient_seen_next;
    logic [7:0]  pulse_target_reg, pulse_target_next;
    logic [7:0]  on_units_reg, on_units_next;
    logic [7:0]  off_units_reg, off_units_next;
    logic [7:0]  declared_length_reg, declared_length_next;
    logic [8:0]  payload_count_reg, payload_count_next;
    logic        active_flag_reg, active_flag_next;
    logic        drive_level_reg, drive_level_next;
    logic [14:0] phase_timer_reg, phase_timer_next;
    logic [7:0]  pulses_done_reg, pulses_done_next;

    // Result register
    logic        out_valid_reg;
    status_t     status_reg, status_next;

    logic        in_fire;
    logic        done_at_start;
    logic        done_after_tick;
    logic [7:0]  pulses_inc;
    logic [14:0] off_limit;
    logic [14:0] on_limit;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Phase limits in ms, at most 25500 so they fit the timer width
    assign off_limit = 15'(off_units_reg) * UNIT_MS;
    assign on_limit  = 15'(on_units_reg) * UNIT_MS;
    assign pulses_inc = pulses_done_reg + 8'd1;

    // Next state for one accepted beat
    always_comb
    begin
        startup_elapsed_next = startup_elapsed_reg;
        startup_done_next    = startup_done_reg;
        byte_position_next   = byte_position_reg;
        recipient_seen_next  = recipient_seen_reg;
        pulse_target_next    = pulse_target_reg;
        on_units_next        = on_units_reg;
        off_units_next       = off_units_reg;
        declared_length_next = declared_length_reg;
        payload_count_next   = payload_count_reg;
        active_flag_next     = active_flag_reg;
        drive_level_next     = drive_level_reg;
        phase_timer_next     = phase_timer_reg;
        pulses_done_next     = pulses_done_reg;
        status_next          = STATUS_NONE;
        done_at_start        = startup_done_reg || (startup_elapsed_reg >= startup_hold_reg);
        done_after_tick      = done_at_start;

        if (in_fire)
        begin
            startup_done_next = done_at_start;
            if (in_ch.command == CMD_BYTE)
            begin
                if (!done_at_start)
                begin
                    // Still in startup hold: drop the byte
                    byte_position_next = '0;
                    payload_count_next = '0;
                    status_next        = in_ch.last_byte ? STATUS_STARTUP : STATUS_NONE;
                end
                else
                begin
                    // Latch header fields as they pass
                    unique case (byte_position_reg)
                        POS_RECIPIENT:   recipient_seen_next  = in_ch.data_byte;
                        POS_PULSE_COUNT: pulse_target_next    = in_ch.data_byte;
                        POS_ON_TIME:     on_units_next        = in_ch.data_byte;
                        POS_OFF_TIME:    off_units_next       = in_ch.data_byte;
                        POS_LENGTH:      declared_length_next = in_ch.data_byte;
                        POS_PAYLOAD:
                        begin
                            if (payload_count_reg != PAYLOAD_MAX)
                                payload_count_next = payload_count_reg + 9'd1;
                        end
                        default: ;
                    endcase

                    if (!in_ch.last_byte)
                    begin
                        if (byte_position_reg != POS_PAYLOAD)
                            byte_position_next = byte_position_reg + 3'd1;
                    end
                    else
                    begin
                        // End of packet: judge it
                        priority if (byte_position_reg < POS_LENGTH)
                            status_next = STATUS_BAD_LENGTH;
                        else if (payload_count_next != {1'b0, declared_length_next})
                            status_next = STATUS_BAD_LENGTH;
                        else if (recipient_seen_next != local_address_reg &&
                                 recipient_seen_next != BROADCAST_ADDR)
                            status_next = STATUS_NOT_ADDR;
                        else
                        begin
                            status_next      = STATUS_ACCEPTED;
                            pulses_done_next = '0;
                            phase_timer_next = '0;
                            drive_level_next = 1'b0;
                            active_flag_next = (pulse_target_next != 8'd0);
                        end
                        byte_position_next = '0;
                        payload_count_next = '0;
                    end
                end
            end
            else
            begin
                // Millisecond tick: advance startup count, then the pattern
                if (startup_elapsed_reg != ELAPSED_MAX)
                    startup_elapsed_next = startup_elapsed_reg + 16'd1;
                done_after_tick   = done_at_start || (startup_elapsed_next >= startup_hold_reg);
                startup_done_next = done_after_tick;

                if (done_after_tick && active_flag_reg)
                begin
                    if (phase_timer_reg != PHASE_MAX)
                        phase_timer_next = phase_timer_reg + 15'd1;
                    if (!drive_level_reg)
                    begin
                        if (phase_timer_next >= off_limit)
                        begin
                            drive_level_next = 1'b1;
                            phase_timer_next = '0;
                        end
                    end
                    else if (phase_timer_next >= on_limit)
                    begin
                        drive_level_next = 1'b0;
                        phase_timer_next = '0;
                        pulses_done_next = pulses_inc;
                        if (pulses_inc == pulse_target_reg)
                            active_flag_next = 1'b0;
                    end
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= LOCAL_ADDR_RESET;
            startup_hold_reg  <= STARTUP_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOCAL_ADDRESS: local_address_reg <= cfg_data[7:0];
                CFG_STARTUP_HOLD:  startup_hold_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Block state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_elapsed_reg <= '0;
            startup_done_reg    <= 1'b0;
            byte_position_reg   <= '0;
            recipient_seen_reg  <= '0;
            pulse_target_reg    <= 8'd3;
            on_units_reg        <= 8'd5;
            off_units_reg       <= 8'd2;
            declared_length_reg <= '0;
            payload_count_reg   <= '0;
            active_flag_reg     <= 1'b0;
            drive_level_reg     <= 1'b0;
            phase_timer_reg     <= '0;
            pulses_done_reg     <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            startup_elapsed_reg <= startup_elapsed_next;
            startup_done_reg    <= startup_done_next;
            byte_position_reg   <= byte_position_next;
            recipient_seen_reg  <= recipient_seen_next;
            pulse_target_reg    <= pulse_target_next;
            on_units_reg        <= on_units_next;
            off_units_reg       <= off_units_next;
            declared_length_reg <= declared_length_next;
            payload_count_reg   <= payload_count_next;
            active_flag_reg     <= active_flag_next;
            drive_level_reg     <= drive_level_next;
            phase_timer_reg     <= phase_timer_next;
            pulses_done_reg     <= pulses_done_next;
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
            status_reg <= status_next;
    end

    // Drive level and activity only change on accepted beats, so the
    // state registers double as the result fields
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.motor_drive    = drive_level_reg;
    assign out_ch.pattern_active = active_flag_reg;
    assign out_ch.packet_status  = status_reg;

    // Output is only driven inside a running pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        drive_level_reg |-> active_flag_reg)
        else $error("alert drive high without an active pattern");

    // No pattern can start before the startup hold ends
    assert property (@(posedge clk) disable iff (!rst_n)
        !startup_done_reg |-> !active_flag_reg)
        else $error("pattern active during startup hold");

    // Startup completion never reverts
    assert property (@(posedge clk) disable iff (!rst_n)
        startup_done_reg |=> startup_done_reg)
        else $error("startup done flag cleared");

    // Input back-pressure only comes from a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_valid_reg && !out_ch.ready))
        else $error("input stalled without a pending result");

endmodule
